// ===== rtl/core/atkm_pkg.sv =====
// shared types, constants and the character classifier for the ascii to key matrix unit
package atkm_pkg;

    // character codes with special handling
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LT     = 8'h3C;
    localparam logic [7:0] CHAR_EQ     = 8'h3D;
    localparam logic [7:0] CHAR_GT     = 8'h3E;
    localparam logic [7:0] CHAR_LBRACK = 8'h5B;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_RBRACK = 8'h5D;
    localparam logic [7:0] CHAR_CARET  = 8'h5E;
    localparam logic [7:0] CHAR_LBRACE = 8'h7B;
    localparam logic [7:0] CHAR_BAR    = 8'h7C;
    localparam logic [7:0] CHAR_RBRACE = 8'h7D;
    localparam logic [7:0] CHAR_TILDE  = 8'h7E;

    // first codes and end codes (exclusive) of the lookup ranges
    localparam logic [7:0] CTL_BASE   = 8'd8;
    localparam logic [7:0] NUM_BASE   = 8'd32;
    localparam logic [7:0] UPPER_BASE = 8'd63;
    localparam logic [7:0] LOWER_BASE = 8'd95;
    localparam logic [7:0] CTL_END    = 8'd10;
    localparam logic [7:0] NUM_END    = 8'd60;
    localparam logic [7:0] UPPER_END  = 8'd91;
    localparam logic [7:0] LOWER_END  = 8'd123;

    // strobe kinds
    localparam logic KIND_PRINT = 1'b0;
    localparam logic KIND_FEED  = 1'b1;

    // fixed switch patterns
    localparam logic [15:0] PAT_LF     = 16'h2001;
    localparam logic [15:0] PAT_BS     = 16'h0801;
    localparam logic [15:0] PAT_LPAREN = 16'h1084;
    localparam logic [15:0] PAT_RPAREN = 16'h2088;
    localparam logic [15:0] PAT_EQ     = 16'h1002;
    localparam logic [15:0] PAT_MINUS  = 16'h2002;
    localparam logic [15:0] PAT_UNDER  = 16'h2082;
    localparam logic [15:0] PAT_BSLASH = 16'h8084;
    localparam logic [15:0] PAT_CARET  = 16'h4002;
    localparam logic [15:0] PAT_SPACE  = 16'h0102;
    localparam logic [15:0] PAT_TILDE  = 16'h0202;

    // range lookup tables
    localparam logic [15:0] TAB_CTL [2] = '{16'h0801, 16'h8001};
    localparam logic [15:0] TAB_NUM [28] = '{
        16'h0102, 16'h1088, 16'h0484, 16'h0488, 16'h0288, 16'h0188, 16'h4084, 16'h0404,
        16'h1084, 16'h2088, 16'h0282, 16'h1082, 16'h0804, 16'h2002, 16'h0104, 16'h8002,
        16'h2008, 16'h1008, 16'h0808, 16'h0408, 16'h0208, 16'h0108, 16'h8004, 16'h4004,
        16'h2004, 16'h1004, 16'h0284, 16'h0204
    };
    localparam logic [15:0] TAB_UPPER [28] = '{
        16'h8002, 16'h0888, 16'h80C0, 16'h40C0, 16'h20C0, 16'h10C0, 16'h08C0, 16'h04C0,
        16'h02C0, 16'h01C0, 16'h80A0, 16'h40A0, 16'h20A0, 16'h10A0, 16'h08A0, 16'h04A0,
        16'h02A0, 16'h01A0, 16'h8090, 16'h4090, 16'h2090, 16'h1090, 16'h0890, 16'h0490,
        16'h0290, 16'h0190, 16'h8088, 16'h4088
    };
    localparam logic [15:0] TAB_LOWER [28] = '{
        16'h2082, 16'h0404, 16'h8040, 16'h4040, 16'h2040, 16'h1040, 16'h0840, 16'h0440,
        16'h0240, 16'h0140, 16'h8020, 16'h4020, 16'h2020, 16'h1020, 16'h0820, 16'h0420,
        16'h0220, 16'h0120, 16'h8010, 16'h4010, 16'h2010, 16'h1010, 16'h0810, 16'h0410,
        16'h0210, 16'h0110, 16'h8008, 16'h4008
    };

    // stroke counts
    localparam logic [1:0] CNT_NONE  = 2'd0;
    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_TWO   = 2'd2;
    localparam logic [1:0] CNT_THREE = 2'd3;

    // one character's stroke sequence; strokes after the first are print strokes
    typedef struct packed {
        logic [1:0]  cnt;
        logic        k0;
        logic [15:0] p0;
        logic [15:0] p1;
        logic [15:0] p2;
    } t_cmd;

    // queue status towards the front and back
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    // overstrike: first symbol, backspace, second symbol
    function automatic t_cmd make_three(logic [15:0] a, logic [15:0] b);
        t_cmd cmd;
        cmd.cnt = CNT_THREE;
        cmd.k0  = KIND_PRINT;
        cmd.p0  = a;
        cmd.p1  = PAT_BS;
        cmd.p2  = b;
        return cmd;
    endfunction

    function automatic t_cmd make_one(logic [15:0] a, logic kind);
        t_cmd cmd;
        cmd.cnt = CNT_ONE;
        cmd.k0  = kind;
        cmd.p0  = a;
        cmd.p1  = PAT_BS;
        cmd.p2  = a;
        return cmd;
    endfunction

    // turn one character into its stroke sequence
    function automatic t_cmd classify(logic [7:0] c, logic after_cr);
        t_cmd       cmd;
        logic [7:0] off_ctl;
        logic [7:0] off_num;
        logic [7:0] off_upper;
        logic [7:0] off_lower;
        off_ctl   = c - CTL_BASE;
        off_num   = c - NUM_BASE;
        off_upper = c - UPPER_BASE;
        off_lower = c - LOWER_BASE;
        cmd       = make_one(PAT_LF, KIND_FEED);
        cmd.cnt   = CNT_NONE;
        unique case (c)
            CHAR_LF: begin
                if (!after_cr) begin
                    cmd = make_one(PAT_LF, KIND_FEED);
                end
            end
            CHAR_CR:     cmd = make_one(PAT_LF, KIND_FEED);
            CHAR_LT:     cmd = make_three(PAT_LPAREN, PAT_MINUS);
            CHAR_EQ:     cmd = make_one(PAT_EQ, KIND_PRINT);
            CHAR_GT:     cmd = make_three(PAT_RPAREN, PAT_MINUS);
            CHAR_LBRACE: cmd = make_three(PAT_LPAREN, PAT_EQ);
            CHAR_BAR:    cmd = make_three(PAT_LPAREN, PAT_RPAREN);
            CHAR_RBRACE: cmd = make_three(PAT_RPAREN, PAT_EQ);
            CHAR_LBRACK: cmd = make_three(PAT_LPAREN, PAT_UNDER);
            CHAR_BSLASH: cmd = make_one(PAT_BSLASH, KIND_PRINT);
            CHAR_RBRACK: cmd = make_three(PAT_RPAREN, PAT_UNDER);
            CHAR_CARET: begin
                cmd.cnt = CNT_TWO;
                cmd.k0  = KIND_FEED;
                cmd.p0  = PAT_CARET;
                cmd.p1  = PAT_SPACE;
                cmd.p2  = PAT_SPACE;
            end
            CHAR_TILDE:  cmd = make_one(PAT_TILDE, KIND_PRINT);
            default: begin
                priority if (c >= CTL_BASE && c < CTL_END) begin
                    cmd = make_one(TAB_CTL[off_ctl[0]], KIND_PRINT);
                end else if (c >= NUM_BASE && c < NUM_END) begin
                    cmd = make_one(TAB_NUM[off_num[4:0]], KIND_PRINT);
                end else if (c >= UPPER_BASE && c < UPPER_END) begin
                    cmd = make_one(TAB_UPPER[off_upper[4:0]], KIND_PRINT);
                end else if (c >= LOWER_BASE && c < LOWER_END) begin
                    cmd = make_one(TAB_LOWER[off_lower[4:0]], KIND_PRINT);
                end else begin
                    cmd.cnt = CNT_NONE;
                end
            end
        endcase
        return cmd;
    endfunction

endpackage

// ===== rtl/core/atkm_front.sv =====
// front end: accepts characters, tracks carriage return, pushes stroke sequences
module atkm_front import atkm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // char_code[7:0]
    input  t_q_status  i_q_status,
    output logic       o_push,
    output t_cmd       o_push_data
);

    logic r_after_cr;
    logic n_after_cr;
    logic w_accept;
    t_cmd w_cmd;

    // handshake and classification
    assign o_s_tready  = !i_q_status.full;
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_cmd       = classify(i_s_tdata, r_after_cr);
    assign o_push      = w_accept && (w_cmd.cnt != CNT_NONE);
    assign o_push_data = w_cmd;

    // carriage return flag: only a cr leaves it set
    always_comb begin
        n_after_cr = r_after_cr;
        if (w_accept) begin
            n_after_cr = (i_s_tdata == CHAR_CR);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after_cr <= 1'b0;
        end else begin
            r_after_cr <= n_after_cr;
        end
    end

    // an lf straight after a cr is swallowed
    a_lf_swallowed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_after_cr && i_s_tdata == CHAR_LF) |-> !o_push)
        else $error("lf after cr was pushed");

endmodule

// ===== rtl/core/atkm_queue.sv =====
// short register queue of stroke sequences between front and back
module atkm_queue import atkm_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_push_data,
    input  logic      i_pop,
    output t_cmd      o_head,
    output t_q_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_store [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == CNT_FULL);
    assign o_head         = r_store[r_rd_ptr];
    assign w_do_push      = i_push && !o_status.full;
    assign w_do_pop       = i_pop && !o_status.empty;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({w_do_push, w_do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_store[r_wr_ptr] <= i_push_data;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.full |-> !i_push)
        else $error("item pushed into full queue");

    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_do_push && !w_do_pop) |=> !o_status.empty)
        else $error("queue empty after push");

endmodule

// ===== rtl/core/atkm_back.sv =====
// back end: steps through each stroke sequence into the output register
module atkm_back import atkm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_head,
    input  t_q_status   i_q_status,
    output logic        o_pop,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,  // switch_pattern[15:0]
    output logic        o_m_tuser,  // strobe_kind
    output logic        o_m_tlast   // last
);

    localparam logic [1:0] STEP_FIRST  = 2'd0;
    localparam logic [1:0] STEP_SECOND = 2'd1;
    localparam logic [1:0] STEP_THIRD  = 2'd2;

    logic        r_valid;
    logic [15:0] r_pat;
    logic        r_kind;
    logic        r_last;
    logic [1:0]  r_step;
    logic        n_valid;
    logic [1:0]  n_step;
    logic        w_load;
    logic        w_final;
    logic [15:0] w_pat;
    logic        w_kind;

    // output register may take a new item when empty or being drained
    assign w_load  = !r_valid || i_m_tready;
    assign w_final = (r_step == (i_head.cnt - 2'd1));
    assign o_pop   = w_load && !i_q_status.empty && w_final;

    // stroke select
    always_comb begin
        unique case (r_step)
            STEP_FIRST: begin
                w_pat  = i_head.p0;
                w_kind = i_head.k0;
            end
            STEP_SECOND: begin
                w_pat  = i_head.p1;
                w_kind = KIND_PRINT;
            end
            default: begin
                w_pat  = i_head.p2;
                w_kind = KIND_PRINT;
            end
        endcase
    end

    // step counter and valid flag
    always_comb begin
        n_valid = r_valid;
        n_step  = r_step;
        if (w_load) begin
            n_valid = !i_q_status.empty;
            if (!i_q_status.empty) begin
                n_step = w_final ? STEP_FIRST : r_step + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= STEP_FIRST;
        end else begin
            r_valid <= n_valid;
            r_step  <= n_step;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_load && !i_q_status.empty) begin
            r_pat  <= w_pat;
            r_kind <= w_kind;
            r_last <= w_final;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_pat;
    assign o_m_tuser  = r_kind;
    assign o_m_tlast  = r_last;

    a_mid_seq_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != STEP_FIRST) |-> (!i_q_status.empty && r_step < i_head.cnt))
        else $error("sequence step without matching queue head");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step != 2'd3)
        else $error("step counter out of range");

    a_pop_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_step == STEP_FIRST && o_m_tvalid && o_m_tlast))
        else $error("pop did not finish a sequence");

endmodule

// ===== rtl/core/ascii_to_typewriter_key_matrix_unit.sv =====
// top level of the ascii to typewriter key matrix unit
// the first stroke of a character is registered in the queue and then in the output register
// throughput: one stroke per cycle from the back end while the queue holds a character and the receiver is ready
// the front takes one character per cycle while the queue of QUEUE_DEPTH entries has room
// characters that give no stroke are accepted by the front but never reach the queue
// reset (synchronous, active low) empties queue and output register and clears the cr flag
module ascii_to_typewriter_key_matrix_unit import atkm_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // char_code[7:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // switch_pattern[15:0]
    output logic        o_m_tuser,   // strobe_kind
    output logic        o_m_tlast    // last
);

    logic      w_push;
    t_cmd      w_push_data;
    logic      w_pop;
    t_cmd      w_head;
    t_q_status w_q_status;

    // classify characters
    atkm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_q_status  (w_q_status),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    // decoupling queue
    atkm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_status    (w_q_status)
    );

    // emit strokes
    atkm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_q_status (w_q_status),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// ===== tb/ascii_to_typewriter_key_matrix_unit_tb.sv =====
// self-checking testbench for the ascii to typewriter key matrix unit
module ascii_to_typewriter_key_matrix_unit_tb;
    import atkm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // one stroke as it leaves the block
    typedef struct packed {
        logic [15:0] pattern;
        logic        kind;
        logic        last;
    } t_stroke;

    // fixed key patterns
    localparam logic [15:0] KEY_LINE_FEED = 16'h2001;
    localparam logic [15:0] KEY_BACKSPACE = 16'h0801;
    localparam logic [15:0] KEY_LPAREN    = 16'h1084;
    localparam logic [15:0] KEY_RPAREN    = 16'h2088;
    localparam logic [15:0] KEY_EQUALS    = 16'h1002;
    localparam logic [15:0] KEY_MINUS     = 16'h2002;
    localparam logic [15:0] KEY_UNDERLINE = 16'h2082;
    localparam logic [15:0] KEY_BACKSLASH = 16'h8084;
    localparam logic [15:0] KEY_CARET     = 16'h4002;
    localparam logic [15:0] KEY_SPACE     = 16'h0102;
    localparam logic [15:0] KEY_TILDE     = 16'h0202;

    // keyboard layout by code range
    localparam logic [15:0] CTL_KEYS [2] = '{16'h0801, 16'h8001};
    localparam logic [15:0] DIGIT_ROW_KEYS [28] = '{
        16'h0102, 16'h1088, 16'h0484, 16'h0488, 16'h0288, 16'h0188, 16'h4084, 16'h0404,
        16'h1084, 16'h2088, 16'h0282, 16'h1082, 16'h0804, 16'h2002, 16'h0104, 16'h8002,
        16'h2008, 16'h1008, 16'h0808, 16'h0408, 16'h0208, 16'h0108, 16'h8004, 16'h4004,
        16'h2004, 16'h1004, 16'h0284, 16'h0204
    };
    localparam logic [15:0] CAPITAL_KEYS [28] = '{
        16'h8002, 16'h0888, 16'h80C0, 16'h40C0, 16'h20C0, 16'h10C0, 16'h08C0, 16'h04C0,
        16'h02C0, 16'h01C0, 16'h80A0, 16'h40A0, 16'h20A0, 16'h10A0, 16'h08A0, 16'h04A0,
        16'h02A0, 16'h01A0, 16'h8090, 16'h4090, 16'h2090, 16'h1090, 16'h0890, 16'h0490,
        16'h0290, 16'h0190, 16'h8088, 16'h4088
    };
    localparam logic [15:0] SMALL_LETTER_KEYS [28] = '{
        16'h2082, 16'h0404, 16'h8040, 16'h4040, 16'h2040, 16'h1040, 16'h0840, 16'h0440,
        16'h0240, 16'h0140, 16'h8020, 16'h4020, 16'h2020, 16'h1020, 16'h0820, 16'h0420,
        16'h0220, 16'h0120, 16'h8010, 16'h4010, 16'h2010, 16'h1010, 16'h0810, 16'h0410,
        16'h0210, 16'h0110, 16'h8008, 16'h4008
    };

    // characters typed by overstrike or a fixed pattern
    localparam logic [7:0] SYMBOL_CHARS [11] = '{
        CHAR_LT, CHAR_EQ, CHAR_GT, CHAR_LBRACE, CHAR_BAR, CHAR_RBRACE,
        CHAR_LBRACK, CHAR_BSLASH, CHAR_RBRACK, CHAR_CARET, CHAR_TILDE
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [15:0] o_m_tdata;
    logic        o_m_tuser;
    logic        o_m_tlast;

    t_stroke expected_strokes [$];
    logic    saw_carriage_return = 1'b0;
    int      error_count = 0;
    int      typed_items = 0;
    int      sender_idle_pct = 0;
    int      receiver_stall_pct = 0;

    ascii_to_typewriter_key_matrix_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),     // char_code[7:0]
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),   // switch_pattern[15:0]
        .o_m_tuser  (o_m_tuser),   // strobe_kind
        .o_m_tlast  (o_m_tlast)    // last
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #2ms;
        $display("FAIL");
        $finish;
    end

    function automatic void push_stroke(input logic [15:0] pattern, input logic kind,
                                        input logic last);
        t_stroke s;
        s.pattern = pattern;
        s.kind    = kind;
        s.last    = last;
        expected_strokes.push_back(s);
    endfunction

    // symbol, backspace, second symbol
    function automatic void push_overstrike(input logic [15:0] first, input logic [15:0] second);
        push_stroke(first, KIND_PRINT, 1'b0);
        push_stroke(KEY_BACKSPACE, KIND_PRINT, 1'b0);
        push_stroke(second, KIND_PRINT, 1'b1);
    endfunction

    // work out the strokes for one character; returns how many
    function automatic int predict_key_strokes(input logic [7:0] code);
        int         queued_before;
        logic [7:0] off_ctl;
        logic [7:0] off_num;
        logic [7:0] off_upper;
        logic [7:0] off_lower;
        queued_before = expected_strokes.size();
        off_ctl       = code - CTL_BASE;
        off_num       = code - NUM_BASE;
        off_upper     = code - UPPER_BASE;
        off_lower     = code - LOWER_BASE;
        if (code == CHAR_LF) begin
            if (saw_carriage_return) begin
                saw_carriage_return = 1'b0;
            end else begin
                push_stroke(KEY_LINE_FEED, KIND_FEED, 1'b1);
            end
        end else if (code == CHAR_CR) begin
            saw_carriage_return = 1'b1;
            push_stroke(KEY_LINE_FEED, KIND_FEED, 1'b1);
        end else begin
            saw_carriage_return = 1'b0;
            case (code)
                CHAR_LT:     push_overstrike(KEY_LPAREN, KEY_MINUS);
                CHAR_EQ:     push_stroke(KEY_EQUALS, KIND_PRINT, 1'b1);
                CHAR_GT:     push_overstrike(KEY_RPAREN, KEY_MINUS);
                CHAR_LBRACE: push_overstrike(KEY_LPAREN, KEY_EQUALS);
                CHAR_BAR:    push_overstrike(KEY_LPAREN, KEY_RPAREN);
                CHAR_RBRACE: push_overstrike(KEY_RPAREN, KEY_EQUALS);
                CHAR_LBRACK: push_overstrike(KEY_LPAREN, KEY_UNDERLINE);
                CHAR_BSLASH: push_stroke(KEY_BACKSLASH, KIND_PRINT, 1'b1);
                CHAR_RBRACK: push_overstrike(KEY_RPAREN, KEY_UNDERLINE);
                CHAR_CARET: begin
                    // dead accent then a space
                    push_stroke(KEY_CARET, KIND_FEED, 1'b0);
                    push_stroke(KEY_SPACE, KIND_PRINT, 1'b1);
                end
                CHAR_TILDE:  push_stroke(KEY_TILDE, KIND_PRINT, 1'b1);
                default: begin
                    if (code >= CTL_BASE && code < CTL_END) begin
                        push_stroke(CTL_KEYS[off_ctl[0]], KIND_PRINT, 1'b1);
                    end else if (code >= NUM_BASE && code < NUM_END) begin
                        push_stroke(DIGIT_ROW_KEYS[off_num[4:0]], KIND_PRINT, 1'b1);
                    end else if (code >= UPPER_BASE && code < UPPER_END) begin
                        push_stroke(CAPITAL_KEYS[off_upper[4:0]], KIND_PRINT, 1'b1);
                    end else if (code >= LOWER_BASE && code < LOWER_END) begin
                        push_stroke(SMALL_LETTER_KEYS[off_lower[4:0]], KIND_PRINT, 1'b1);
                    end
                end
            endcase
        end
        return expected_strokes.size() - queued_before;
    endfunction

    // offer one character and wait until it is taken; valid stays high unless idling
    task automatic send_char(input logic [7:0] code);
        int n_strokes;
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom_range(255));
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        n_strokes = predict_key_strokes(code);
        if (n_strokes != 0) typed_items++;
    endtask

    // output handshake, random stalls and the stroke check
    always @(posedge i_clk) begin
        t_stroke want;
        if (i_rst_n && o_m_tvalid && m_tready) begin
            if (expected_strokes.size() == 0) begin
                $error("unexpected stroke pattern %h kind %b last %b",
                       o_m_tdata, o_m_tuser, o_m_tlast);
                error_count++;
            end else begin
                want = expected_strokes.pop_front();
                if (o_m_tdata !== want.pattern) begin
                    $error("switch_pattern expected %h actual %h", want.pattern, o_m_tdata);
                    error_count++;
                end
                if (o_m_tuser !== want.kind) begin
                    $error("strobe_kind expected %b actual %b", want.kind, o_m_tuser);
                    error_count++;
                end
                if (o_m_tlast !== want.last) begin
                    $error("last expected %b actual %b", want.last, o_m_tlast);
                    error_count++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // line feed alone, swallowed after a carriage return, and flag clearing
    task automatic test_line_endings();
        send_char(CHAR_LF);
        send_char(CHAR_CR);
        send_char(CHAR_LF);
        send_char(CHAR_LF);
        send_char(CHAR_CR);
        send_char(8'h61);
        send_char(CHAR_LF);
        send_char(CHAR_CR);
        send_char(CHAR_CR);
        send_char(CHAR_LF);
    endtask

    // overstrikes, accent and the single fixed symbols
    task automatic test_symbols();
        foreach (SYMBOL_CHARS[i]) send_char(SYMBOL_CHARS[i]);
    endtask

    // ends of the code space, the top of the control range and the base of the number range
    task automatic test_range_edges();
        send_char(8'h00);
        send_char(8'hFF);
        send_char(CTL_END - 8'd1);
        send_char(NUM_BASE);
    endtask

    // mostly text with line endings and symbols, some raw bytes
    task automatic test_random_text(input int n_items, input int send_idle, input int recv_stall);
        int roll;
        int goal;
        sender_idle_pct    = send_idle;
        receiver_stall_pct = recv_stall;
        goal = typed_items + n_items;
        while (typed_items < goal) begin
            roll = $urandom_range(99);
            if (roll < 10) begin
                if ($urandom_range(3) != 0) send_char(CHAR_CR);
                if ($urandom_range(3) != 0) send_char(CHAR_LF);
            end else if (roll < 24) begin
                send_char(SYMBOL_CHARS[$urandom_range(10)]);
            end else if (roll < 36) begin
                send_char(8'($urandom_range(255)));
            end else begin
                send_char(8'($urandom_range(126, 32)));
            end
        end
    endtask

    // reset, then the tests in turn
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_line_endings();
        test_symbols();
        test_range_edges();
        test_random_text(62, 0, 0);
        test_random_text(62, 83, 0);
        test_random_text(62, 0, 83);
        test_random_text(62, 26, 26);
        s_tvalid <= 1'b0;
        while (expected_strokes.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
